/* src/window_3x3_filter_defines.svh */
// Assertion macros shared by the window filter RTL.
`ifndef WINDOW_3X3_FILTER_DEFINES_SVH
`define WINDOW_3X3_FILTER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define WF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define WF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/wf_pkg.sv */
// Types and constants shared by the 3x3 window filter modules.
package wf_pkg;

    typedef logic [31:0] pixel_t;

    // Window pixels, index = column * 3 + row (column 0 left, row 0 top).
    typedef pixel_t [8:0] win_t;

    typedef enum logic [1:0] {
        MODE_BOX   = 2'd0,
        MODE_GAUSS = 2'd1,
        MODE_EDGE  = 2'd2,
        MODE_PASS  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_MODE   = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_PTR_W = 4;
    localparam int FIFO_CNT_W = 5;

    // Reciprocal multipliers: floor(s/9) for s <= 2295, floor(t/100) for t <= 25245.
    localparam logic [12:0] RECIP9     = 13'd7282;
    localparam int          RECIP9_SH  = 16;
    localparam logic [12:0] RECIP100   = 13'd5243;
    localparam int          RECIP100_SH = 19;

    // Per-item bookkeeping carried along the datapath.
    typedef struct packed {
        logic        filt_v;
        logic        bord_v;
        pixel_t      px;
        logic [9:0]  fx;
        logic [11:0] fy;
        logic [9:0]  bx;
        logic [11:0] by;
    } meta_t;

    typedef struct packed {
        logic        last;
        logic [11:0] pos_y;
        logic [9:0]  pos_x;
        pixel_t      pix;
    } entry_t;

    // Gaussian weight 1-2-1 / 2-4-2 / 1-2-1 at a window index.
    function automatic logic [2:0] gauss_w(input int idx);
        logic [2:0] w;
        if (idx == 4)
            w = 3'd4;
        else if (idx == 1 || idx == 3 || idx == 5 || idx == 7)
            w = 3'd2;
        else
            w = 3'd1;
        return w;
    endfunction

endpackage

/* src/wf_line_store.sv */
// Two line memories (row above, two rows above) with write-to-read forwarding.
module wf_line_store #(
    parameter int AW = 10,
    parameter int DEPTH = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  wf_pkg::pixel_t   wr_top,
    input  wf_pkg::pixel_t   wr_mid,
    output wf_pkg::pixel_t   rd_top,
    output wf_pkg::pixel_t   rd_mid
);
    import wf_pkg::*;

    pixel_t top_mem [DEPTH];
    pixel_t mid_mem [DEPTH];
    pixel_t top_q_reg;
    pixel_t mid_q_reg;
    pixel_t fwd_top_reg;
    pixel_t fwd_mid_reg;
    logic   fwd_reg;

    // Read and write the line memories
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            top_q_reg <= top_mem[rd_addr];
            mid_q_reg <= mid_mem[rd_addr];
        end
        if (wr_en)
        begin
            top_mem[wr_addr] <= wr_top;
            mid_mem[wr_addr] <= wr_mid;
        end
    end

    // Capture a write that lands on the entry being read in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_reg <= 1'b0;
        else if (rd_en)
            fwd_reg <= wr_en && (wr_addr == rd_addr);
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_top_reg <= wr_top;
            fwd_mid_reg <= wr_mid;
        end
    end

    assign rd_top = fwd_reg ? fwd_top_reg : top_q_reg;
    assign rd_mid = fwd_reg ? fwd_mid_reg : mid_q_reg;

endmodule

/* src/wf_kernel.sv */
// Three-stage filter arithmetic: sums, reciprocal divides, Laplacian and mode select.
module wf_kernel (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  wf_pkg::win_t    win,
    input  wf_pkg::meta_t   in_meta,
    input  wf_pkg::mode_t   mode,
    output logic            out_valid,
    output wf_pkg::pixel_t  out_pix,
    output wf_pkg::meta_t   out_meta
);
    import wf_pkg::*;

    // Stage A: sums
    logic          a_valid_reg;
    meta_t         a_meta_reg;
    pixel_t        a_cen_reg;
    logic [11:0]   a_box_reg  [3];
    logic [11:0]   a_gs_reg   [3];
    logic [14:0]   a_gt_reg   [9];
    logic [11:0]   a_box_next [3];
    logic [11:0]   a_gs_next  [3];
    logic [14:0]   a_gt_next  [9];

    // Stage B: quotients
    logic          b_valid_reg;
    meta_t         b_meta_reg;
    pixel_t        b_cen_reg;
    logic [7:0]    b_box_reg  [3];
    logic [7:0]    b_gs_reg   [3];
    logic [7:0]    b_gray_reg [9];
    logic [7:0]    b_box_next [3];
    logic [7:0]    b_gs_next  [3];
    logic [7:0]    b_gray_next [9];

    // Stage C: result
    logic          c_valid_reg;
    meta_t         c_meta_reg;
    pixel_t        c_pix_reg;
    pixel_t        c_pix_next;
    logic [10:0]   nb_sum;
    logic [7:0]    lap;

    // Form channel sums and gray numerators
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            a_box_next[k] = '0;
            a_gs_next[k]  = '0;
            for (int i = 0; i < 9; i++)
            begin
                a_box_next[k] = a_box_next[k] + 12'(win[i][8*k +: 8]);
                a_gs_next[k]  = a_gs_next[k]
                              + 12'(win[i][8*k +: 8]) * 12'(gauss_w(i));
            end
        end
        for (int i = 0; i < 9; i++)
        begin
            a_gt_next[i] = 15'(win[i][7:0]) * 15'd29
                         + 15'(win[i][15:8]) * 15'd59
                         + 15'(win[i][23:16]) * 15'd11;
        end
    end

    always_ff @(posedge clk)
    begin
        a_meta_reg <= in_meta;
        a_cen_reg  <= win[4];
        a_box_reg  <= a_box_next;
        a_gs_reg   <= a_gs_next;
        a_gt_reg   <= a_gt_next;
    end

    // Divide by constants
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            b_box_next[k] = 8'((25'(a_box_reg[k]) * 25'(RECIP9)) >> RECIP9_SH);
            b_gs_next[k]  = 8'(a_gs_reg[k] >> 4);
        end
        for (int i = 0; i < 9; i++)
        begin
            b_gray_next[i] = 8'((28'(a_gt_reg[i]) * 28'(RECIP100)) >> RECIP100_SH);
        end
    end

    always_ff @(posedge clk)
    begin
        b_meta_reg <= a_meta_reg;
        b_cen_reg  <= a_cen_reg;
        b_box_reg  <= b_box_next;
        b_gs_reg   <= b_gs_next;
        b_gray_reg <= b_gray_next;
    end

    // Laplacian and mode select
    always_comb
    begin
        nb_sum = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4)
                nb_sum = nb_sum + 11'(b_gray_reg[i]);
        end
        lap = 8'({b_gray_reg[4], 3'b000}) - nb_sum[7:0];
        unique case (mode)
            MODE_BOX:   c_pix_next = {b_cen_reg[31:24], b_box_reg[2], b_box_reg[1],
                                      b_box_reg[0]};
            MODE_GAUSS: c_pix_next = {b_cen_reg[31:24], b_gs_reg[2], b_gs_reg[1],
                                      b_gs_reg[0]};
            MODE_EDGE:  c_pix_next = {b_cen_reg[31:24], lap, lap, lap};
            MODE_PASS:  c_pix_next = b_cen_reg;
            default:    c_pix_next = b_cen_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        c_meta_reg <= b_meta_reg;
        c_pix_reg  <= c_pix_next;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_pix   = c_pix_reg;
    assign out_meta  = c_meta_reg;

endmodule

/* src/wf_out_fifo.sv */
// Result queue taking up to two items per cycle and giving one.
module wf_out_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push0,
    input  wf_pkg::entry_t                push0_data,
    input  logic                          push1,
    input  wf_pkg::entry_t                push1_data,
    input  logic                          pop,
    output logic                          valid,
    output wf_pkg::entry_t                head,
    output logic [wf_pkg::FIFO_CNT_W-1:0] count
);
    import wf_pkg::*;

    entry_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr1;
    logic                  do_pop;

    assign wr_ptr1 = wr_ptr_reg + FIFO_PTR_W'(1);
    assign do_pop  = pop && (count_reg != '0);

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (push0)
            mem[wr_ptr_reg] <= push0_data;
        if (push1)
            mem[wr_ptr1] <= push1_data;
    end

    // Move pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(push0) + FIFO_PTR_W'(push1);
            rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(do_pop);
            count_reg  <= count_reg + FIFO_CNT_W'(push0) + FIFO_CNT_W'(push1)
                        - FIFO_CNT_W'(do_pop);
        end
    end

    assign valid = count_reg != '0;
    assign head  = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

/* src/window_3x3_filter.sv */
// Top level of the streaming 3x3 window filter on RGBA pixels.
// An accepted item passes the read register and kernel stages A, B and C before the queue.
// Throughput: one input item per cycle; the limit is the single line-memory port pair
// read and written once per item, plus room in the 16-entry result queue.
// Reset: counters, window and queue clear; width 640, height 480, mode box blur.
// Line memories hold no reset value and need no clearing pass.
module window_3x3_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // in_red, in_green, in_blue, in_alpha
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // out_red, out_green, out_blue, out_alpha, pos_x, pos_y
    output logic        m_tlast,    // last_of_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    import wf_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int HW  = $clog2(MAX_HEIGHT);
    localparam int WDW = $clog2(MAX_WIDTH + 1);
    localparam int HTW = $clog2(MAX_HEIGHT + 1);

    logic [10:0]     width_reg;
    logic [12:0]     height_reg;
    mode_t           mode_reg;
    logic [AW-1:0]   col_reg;
    logic [HW-1:0]   row_reg;
    logic [WDW-1:0]  wd;
    logic [HTW-1:0]  ht;
    logic            accept;
    logic            col_last;
    logic            row_last;
    logic            s1_valid_reg;
    meta_t           s1_meta_reg;
    logic [AW-1:0]   s1_addr_reg;
    meta_t           meta_next;
    pixel_t          win_col_reg [6];
    pixel_t          ls_top;
    pixel_t          ls_mid;
    win_t            win;
    logic            k_valid;
    pixel_t          k_pix;
    meta_t           k_meta;
    logic [2:0]      inflight_reg;
    logic            push0;
    logic            push1;
    entry_t          push0_data;
    entry_t          push1_data;
    entry_t          head;
    logic [FIFO_CNT_W-1:0] fifo_count;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd640;
            height_reg <= 13'd480;
            mode_reg   <= MODE_BOX;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_WIDTH:  width_reg  <= cfg_data[10:0];
                REG_HEIGHT: height_reg <= cfg_data;
                REG_MODE:   mode_reg   <= mode_t'(cfg_data[1:0]);
                REG_NONE:   ;
                default:    ;
            endcase
        end
    end

    // Clamp frame size to the supported range
    always_comb
    begin
        if (width_reg == '0)
            wd = WDW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            wd = WDW'(MAX_WIDTH);
        else
            wd = WDW'(width_reg);
        if (height_reg == '0)
            ht = HTW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            ht = HTW'(MAX_HEIGHT);
        else
            ht = HTW'(height_reg);
    end

    // Admit an item only while the queue has room for all results in flight
    assign s_tready = (32'(fifo_count) + 32'(inflight_reg) * 2 + 2) <= FIFO_DEPTH;
    assign accept   = s_tvalid && s_tready;

    assign col_last = (32'(col_reg) + 32'd1) >= 32'(wd);
    assign row_last = (32'(row_reg) + 32'd1) >= 32'(ht);

    // Classify the arriving pixel and tag coordinates
    always_comb
    begin
        meta_next.px     = s_tdata;
        meta_next.filt_v = (col_reg >= AW'(2)) && (row_reg >= HW'(2))
                         && (32'(col_reg) < 32'(wd)) && (32'(row_reg) < 32'(ht));
        meta_next.bord_v = (col_reg == '0) || (row_reg == '0) || col_last || row_last;
        meta_next.fx     = 10'(32'(col_reg) - 32'd1);
        meta_next.fy     = 12'(32'(row_reg) - 32'd1);
        meta_next.bx     = 10'(32'(col_reg));
        meta_next.by     = 12'(32'(row_reg));
    end

    // Advance raster counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (col_last)
            begin
                col_reg <= '0;
                row_reg <= row_last ? '0 : row_reg + HW'(1);
            end
            else
            begin
                col_reg <= col_reg + AW'(1);
            end
        end
    end

    // Hold the item while its line memory read completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg <= meta_next;
            s1_addr_reg <= col_reg;
        end
    end

    wf_line_store #(
        .AW    (AW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_top  (ls_mid),
        .wr_mid  (s1_meta_reg.px),
        .rd_top  (ls_top),
        .rd_mid  (ls_mid)
    );

    // Assemble the 3x3 window
    always_comb
    begin
        win[0] = win_col_reg[3];
        win[1] = win_col_reg[4];
        win[2] = win_col_reg[5];
        win[3] = win_col_reg[0];
        win[4] = win_col_reg[1];
        win[5] = win_col_reg[2];
        win[6] = ls_top;
        win[7] = ls_mid;
        win[8] = s1_meta_reg.px;
    end

    // Shift window columns
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_col_reg[i] <= '0;
        end
        else if (s1_valid_reg)
        begin
            win_col_reg[3] <= win_col_reg[0];
            win_col_reg[4] <= win_col_reg[1];
            win_col_reg[5] <= win_col_reg[2];
            win_col_reg[0] <= ls_top;
            win_col_reg[1] <= ls_mid;
            win_col_reg[2] <= s1_meta_reg.px;
        end
    end

    wf_kernel u_kernel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .win       (win),
        .in_meta   (s1_meta_reg),
        .mode      (mode_reg),
        .out_valid (k_valid),
        .out_pix   (k_pix),
        .out_meta  (k_meta)
    );

    // Count items between acceptance and the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_reg + 3'(accept) - 3'(k_valid);
    end

    // Order results: filtered pixel first, then the border pass-through
    always_comb
    begin
        push0 = k_valid && (k_meta.filt_v || k_meta.bord_v);
        push1 = k_valid && k_meta.filt_v && k_meta.bord_v;
        if (k_meta.filt_v)
        begin
            push0_data.pix   = k_pix;
            push0_data.pos_x = k_meta.fx;
            push0_data.pos_y = k_meta.fy;
            push0_data.last  = !k_meta.bord_v;
        end
        else
        begin
            push0_data.pix   = k_meta.px;
            push0_data.pos_x = k_meta.bx;
            push0_data.pos_y = k_meta.by;
            push0_data.last  = 1'b1;
        end
        push1_data.pix   = k_meta.px;
        push1_data.pos_x = k_meta.bx;
        push1_data.pos_y = k_meta.by;
        push1_data.last  = 1'b1;
    end

    wf_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push0      (push0),
        .push0_data (push0_data),
        .push1      (push1),
        .push1_data (push1_data),
        .pop        (m_tready),
        .valid      (m_tvalid),
        .head       (head),
        .count      (fifo_count)
    );

    assign m_tdata = {2'b00, head.pos_y, head.pos_x, head.pix};
    assign m_tlast = head.last;

    `include "window_3x3_filter_defines.svh"

    `WF_ASSERT_SAME(a_kernel_has_item, k_valid, inflight_reg != '0, "result without item in flight")
    `WF_ASSERT_SAME(a_queue_room, k_valid, (32'(fifo_count) + 2) <= FIFO_DEPTH, "queue overflow")
    `WF_ASSERT_NEXT(a_read_follows, accept, s1_valid_reg, "accepted item lost before read")
    `WF_ASSERT_SAME(a_inflight_bound, 1'b1, inflight_reg <= 3'd4, "too many items in flight")

endmodule

/* dv/window_3x3_filter_tb.sv */
// Testbench for the streaming 3x3 window filter: directed and random frames checked against a predictor.
module window_3x3_filter_tb;
    import wf_pkg::*;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [9:0]  px;
        logic [11:0] py;
        logic        last;
    } filt_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    // Predictor state
    logic [31:0] line_mem [0:2047];
    logic [31:0] win_cols [0:5];
    int unsigned col_cnt;
    int unsigned row_cnt;
    int unsigned img_w;
    int unsigned img_h;
    logic [1:0]  cur_mode;

    filt_res_t   pending_q[$];
    int          fail_cnt;
    int          item_cnt;
    int          result_cnt;
    bit          hold_rx;
    int          rx_wait;

    window_3x3_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned gray_of(logic [31:0] p);
        return (29 * p[7:0] + 59 * p[15:8] + 11 * p[23:16]) / 100;
    endfunction

    // w[col*3+row]
    function automatic logic [31:0] filter_window(logic [31:0] w [0:8]);
        int unsigned s;
        int unsigned wt;
        logic [31:0] res;
        logic [7:0]  g;
        res = {w[4][31:24], 24'd0};
        if (cur_mode == MODE_EDGE)
        begin
            s = 0;
            for (int i = 0; i < 9; i++)
                if (i != 4)
                    s += gray_of(w[i]);
            g = 8 * gray_of(w[4]) - s;
            return {w[4][31:24], g, g, g};
        end
        if (cur_mode == MODE_PASS)
            return w[4];
        for (int k = 0; k < 3; k++)
        begin
            s = 0;
            for (int i = 0; i < 9; i++)
            begin
                wt = (i == 4) ? 4 : ((i % 2) ? 2 : 1);
                s += ((cur_mode == MODE_BOX) ? 1 : wt) * ((w[i] >> (8 * k)) & 8'hFF);
            end
            s = (cur_mode == MODE_BOX) ? s / 9 : s / 16;
            res[8*k +: 8] = s[7:0];
        end
        return res;
    endfunction

    function automatic filt_res_t make_res(logic [31:0] p, int unsigned x, int unsigned y);
        filt_res_t r;
        r.red = p[7:0];
        r.green = p[15:8];
        r.blue = p[23:16];
        r.alpha = p[31:24];
        r.px = x[9:0];
        r.py = y[11:0];
        r.last = 1'b0;
        return r;
    endfunction

    // Advance the predictor by one pixel and queue its results
    task automatic predict_pixel(logic [31:0] pix);
        int unsigned wd;
        int unsigned ht;
        int unsigned ci;
        logic [31:0] top;
        logic [31:0] mid;
        logic [31:0] w [0:8];
        filt_res_t   r [0:1];
        int          n;
        wd = (img_w < 1) ? 1 : ((img_w > 1024) ? 1024 : img_w);
        ht = (img_h < 1) ? 1 : ((img_h > 4096) ? 4096 : img_h);
        ci = (col_cnt < 1024) ? col_cnt : 1023;
        top = line_mem[1024 + ci];
        mid = line_mem[ci];
        n = 0;
        if (col_cnt >= 2 && row_cnt >= 2 && col_cnt < wd && row_cnt < ht)
        begin
            for (int j = 0; j < 3; j++)
            begin
                w[j] = win_cols[3 + j];
                w[3 + j] = win_cols[j];
            end
            w[6] = top;
            w[7] = mid;
            w[8] = pix;
            r[n] = make_res(filter_window(w), col_cnt - 1, row_cnt - 1);
            n++;
        end
        if (col_cnt == 0 || row_cnt == 0 || col_cnt + 1 >= wd || row_cnt + 1 >= ht)
        begin
            r[n] = make_res(pix, col_cnt, row_cnt);
            n++;
        end
        if (n > 0)
            r[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            pending_q.push_back(r[i]);
        line_mem[1024 + ci] = mid;
        line_mem[ci] = pix;
        win_cols[3] = win_cols[0];
        win_cols[4] = win_cols[1];
        win_cols[5] = win_cols[2];
        win_cols[0] = top;
        win_cols[1] = mid;
        win_cols[2] = pix;
        if (col_cnt + 1 >= wd)
        begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= ht) ? 0 : row_cnt + 1;
        end
        else
            col_cnt = col_cnt + 1;
    endtask

    // Send one pixel after a random gap; valid stays high into the next item when there is none
    task automatic send_pixel(logic [31:0] pix, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_pixel(pix);
        item_cnt++;
    endtask

    // Drop valid, wait until every expected result is out, then let the pipeline drain
    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [12:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_WIDTH:  img_w = val[10:0];
            REG_HEIGHT: img_h = val;
            REG_MODE:   cur_mode = val[1:0];
            default: ;
        endcase
    endtask

    task automatic set_frame(int unsigned w, int unsigned h, mode_t m);
        drain();
        write_reg(REG_WIDTH, 13'(w));
        write_reg(REG_HEIGHT, 13'(h));
        write_reg(REG_MODE, 13'(m));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_pixel();
        return $urandom;
    endfunction

    // Directed: extreme values, every mode, small frames
    task automatic test_directed();
        logic [31:0] pat [0:8];
        pat = '{32'h00000000, 32'hFFFFFFFF, 32'hFF00FF00, 32'h00FF00FF, 32'hFFFFFFFF,
                32'h00000000, 32'h80808080, 32'h7F7F7F7F, 32'hFFFFFFFF};
        for (int m = 0; m < 4; m++)
        begin
            set_frame(3, 3, mode_t'(m));
            for (int i = 0; i < 9; i++)
                send_pixel((m == 2 && i == 4) ? 32'hFFFFFFFF : pat[(i + m) % 9], 1);
        end
        // Frames too small to filter
        set_frame(2, 1, MODE_BOX);
        repeat (2) send_pixel(32'hFFFFFFFF);
        set_frame(1, 2, MODE_EDGE);
        repeat (2) send_pixel(32'h00000000);
    endtask

    // Register extremes: zero clamps to one, width at the maximum, oversized sizes written without pixels
    task automatic test_reg_extremes();
        set_frame(0, 0, MODE_GAUSS);
        repeat (3) send_pixel(rand_pixel());
        set_frame(1024, 1, MODE_BOX);
        repeat (6) send_pixel(rand_pixel(), 1);
        set_frame(2047, 8191, MODE_GAUSS);
        drain();
    endtask

    // Random frames of random size and mode, mostly well formed
    task automatic test_random_frames();
        int unsigned w;
        int unsigned h;
        int          budget;
        budget = 0;
        while (budget < 175)
        begin
            w = $urandom_range(3, 7);
            h = $urandom_range(3, 6);
            set_frame(w, h, mode_t'($urandom_range(0, 3)));
            // Restart counters at frame start: fill any partial frame first
            while (col_cnt != 0 || row_cnt != 0)
                send_pixel(rand_pixel());
            for (int i = 0; i < w * h; i++)
            begin
                send_pixel(rand_pixel());
                budget++;
            end
        end
    endtask

    // Output side: check against oldest expectation, then stall a random count per item
    always @(posedge clk)
    begin
        filt_res_t got;
        filt_res_t exp_r;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24],
                       m_tdata[41:32], m_tdata[53:42], m_tlast};
                result_cnt++;
                if (pending_q.size() == 0)
                begin
                    $error("unexpected result x=%0d y=%0d", got.px, got.py);
                    fail_cnt++;
                end
                else
                begin
                    exp_r = pending_q.pop_front();
                    if (got.red != exp_r.red)
                    begin
                        $error("out_red exp %0d got %0d", exp_r.red, got.red);
                        fail_cnt++;
                    end
                    if (got.green != exp_r.green)
                    begin
                        $error("out_green exp %0d got %0d", exp_r.green, got.green);
                        fail_cnt++;
                    end
                    if (got.blue != exp_r.blue)
                    begin
                        $error("out_blue exp %0d got %0d", exp_r.blue, got.blue);
                        fail_cnt++;
                    end
                    if (got.alpha != exp_r.alpha)
                    begin
                        $error("out_alpha exp %0d got %0d", exp_r.alpha, got.alpha);
                        fail_cnt++;
                    end
                    if (got.px != exp_r.px)
                    begin
                        $error("pos_x exp %0d got %0d", exp_r.px, got.px);
                        fail_cnt++;
                    end
                    if (got.py != exp_r.py)
                    begin
                        $error("pos_y exp %0d got %0d", exp_r.py, got.py);
                        fail_cnt++;
                    end
                    if (got.last != exp_r.last)
                    begin
                        $error("last_of_run exp %0d got %0d", exp_r.last, got.last);
                        fail_cnt++;
                    end
                end
                // Draw the wait before the next item, with stretches of none
                rx_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            end
            if (hold_rx || rx_wait == 0)
                m_tready <= 1'b1;
            else
            begin
                m_tready <= 1'b0;
                rx_wait--;
            end
        end
    end

    // Timeout
    initial
    begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data  = '0;
        fail_cnt  = 0;
        item_cnt  = 0;
        result_cnt = 0;
        hold_rx   = 1'b0;
        rx_wait   = 0;
        for (int i = 0; i < 2048; i++)
            line_mem[i] = '0;
        for (int i = 0; i < 6; i++)
            win_cols[i] = '0;
        col_cnt  = 0;
        row_cnt  = 0;
        img_w    = 640;
        img_h    = 480;
        cur_mode = MODE_BOX;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_reg_extremes();
        test_random_frames();
        hold_rx = 1'b1;
        drain();
        if (pending_q.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_q.size());
            fail_cnt++;
        end
        $display("Sent %0d pixels and checked %0d results over all four modes,",
                 item_cnt, result_cnt);
        $display("small, clamped and random frame sizes.");
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
